FILE: hw/rtl/fsbp_pkg.sv
// Package for the funnel shift / byte permute / bit-field insert unit.
// Holds operation codes and operand widths; no dependencies.
package fsbp_pkg;

  // Operand and result widths
  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned FieldW = 8;

  // Operation select codes
  typedef enum logic [1:0] {
    FUNC_SHL  = 2'd0,
    FUNC_SHR  = 2'd1,
    FUNC_PRMT = 2'd2,
    FUNC_BFI  = 2'd3
  } func_e;

endpackage

FILE: hw/rtl/fsbp_shift_perm.sv
// Funnel shift (left/right, wrap) and byte permute datapath.
// Combinational; depends on fsbp_pkg.
module fsbp_shift_perm (
  input  logic                        shift_left_i,
  input  logic [fsbp_pkg::HalfW-1:0]  low_i,
  input  logic [fsbp_pkg::HalfW-1:0]  high_i,
  input  logic [fsbp_pkg::CountW-1:0] count_or_selector_i,
  output logic [fsbp_pkg::HalfW-1:0]  shift_o,
  output logic [fsbp_pkg::HalfW-1:0]  perm_o
);
  import fsbp_pkg::*;

  logic [2*HalfW-1:0] pair;
  logic [2*HalfW-1:0] shl_pair;
  logic [2*HalfW-1:0] shr_pair;
  logic [4:0]         amount;

  assign pair   = {high_i, low_i};
  assign amount = count_or_selector_i[4:0];

  // Funnel shift: keep the upper half on a left shift, lower half on a right
  assign shl_pair = pair << amount;
  assign shr_pair = pair >> amount;
  assign shift_o  = shift_left_i ? shl_pair[2*HalfW-1:HalfW] : shr_pair[HalfW-1:0];

  // Byte permute: one selector nibble per result byte, bit 3 gives sign fill
  always_comb begin
    logic [3:0] nib;
    logic [7:0] pick;
    perm_o = '0;
    for (int lane = 0; lane < 4; lane++) begin
      nib  = count_or_selector_i[lane*4 +: 4];
      pick = pair[nib[2:0]*8 +: 8];
      if (nib[3]) begin
        pick = {8{pick[7]}};
      end
      perm_o[lane*8 +: 8] = pick;
    end
  end

endmodule

FILE: hw/rtl/fsbp_insert.sv
// Bit-field insert datapath, 32- or 64-bit word, with field clamping.
// Combinational; depends on fsbp_pkg.
module fsbp_insert (
  input  logic                        wide_word_i,
  input  logic [fsbp_pkg::WordW-1:0]  operand_a_i,
  input  logic [fsbp_pkg::WordW-1:0]  operand_b_i,
  input  logic [fsbp_pkg::FieldW-1:0] field_position_i,
  input  logic [fsbp_pkg::FieldW-1:0] field_length_i,
  output logic [fsbp_pkg::WordW-1:0]  insert_o
);
  import fsbp_pkg::*;

  logic [WordW-1:0] word_mask;
  logic [WordW-1:0] lo_mask;
  logic [WordW-1:0] hi_mask;
  logic [WordW-1:0] field_mask;
  logic [WordW-1:0] a_shifted;
  logic [FieldW:0]  field_end;
  logic             pos_in_word;
  logic             do_insert;

  assign word_mask = wide_word_i ? {WordW{1'b1}} : {{HalfW{1'b0}}, {HalfW{1'b1}}};

  // Position must fall inside the selected word and length must be nonzero
  assign pos_in_word = wide_word_i ? (field_position_i < FieldW'(WordW))
                                   : (field_position_i < FieldW'(HalfW));
  assign do_insert   = pos_in_word && (field_length_i != '0);

  // Field mask: bits from position up to position+length, clamped to the word
  assign field_end  = {1'b0, field_position_i} + {1'b0, field_length_i};
  assign lo_mask    = {WordW{1'b1}} << field_position_i[5:0];
  assign hi_mask    = (field_end >= (FieldW+1)'(WordW)) ? {WordW{1'b1}}
                                                        : ~({WordW{1'b1}} << field_end[5:0]);
  assign field_mask = lo_mask & hi_mask & word_mask;
  assign a_shifted  = operand_a_i << field_position_i[5:0];

  assign insert_o = do_insert
                  ? (((operand_b_i & ~field_mask) | (a_shifted & field_mask)) & word_mask)
                  : (operand_b_i & word_mask);

endmodule

FILE: hw/rtl/funnel_shift_byte_permute_bitfield_unit_core.sv
// An accepted item passes through the input register and then the result register before result_valid_o rises.
// The input register and result register surround a single-pass datapath; busy_o stays
// low, so start is accepted whenever it is high, even before the last item is through.
// Reset (rst_ni, async active low) clears the valid flags; no result is pending after it.
// The receiver cannot stall: result_valid_o is high for exactly one cycle per item.
// Top level; depends on fsbp_pkg, fsbp_shift_perm, fsbp_insert.
module funnel_shift_byte_permute_bitfield_unit_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  fsbp_pkg::func_e             func_i,
  input  logic                        wide_word_i,
  input  logic [fsbp_pkg::WordW-1:0]  operand_a_i,
  input  logic [fsbp_pkg::WordW-1:0]  operand_b_i,
  input  logic [fsbp_pkg::CountW-1:0] count_or_selector_i,
  input  logic [fsbp_pkg::FieldW-1:0] field_position_i,
  input  logic [fsbp_pkg::FieldW-1:0] field_length_i,
  output logic                        result_valid_o,
  output logic [fsbp_pkg::WordW-1:0]  result_word_o
);
  import fsbp_pkg::*;

  logic               accept;
  logic               in_vld_q;
  func_e              func_q;
  logic               wide_q;
  logic [WordW-1:0]   a_q;
  logic [WordW-1:0]   b_q;
  logic [CountW-1:0]  cs_q;
  logic [FieldW-1:0]  pos_q;
  logic [FieldW-1:0]  len_q;
  logic [HalfW-1:0]   shift_res;
  logic [HalfW-1:0]   perm_res;
  logic [WordW-1:0]   insert_res;
  logic [WordW-1:0]   result_d;
  logic               res_vld_q;
  logic [WordW-1:0]   result_q;

  // Never holds off an item
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Input register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      wide_q <= wide_word_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      cs_q   <= count_or_selector_i;
      pos_q  <= field_position_i;
      len_q  <= field_length_i;
    end
  end

  fsbp_shift_perm u_shift_perm (
    .shift_left_i        (func_q == FUNC_SHL),
    .low_i               (a_q[HalfW-1:0]),
    .high_i              (b_q[HalfW-1:0]),
    .count_or_selector_i (cs_q),
    .shift_o             (shift_res),
    .perm_o              (perm_res)
  );

  fsbp_insert u_insert (
    .wide_word_i      (wide_q),
    .operand_a_i      (a_q),
    .operand_b_i      (b_q),
    .field_position_i (pos_q),
    .field_length_i   (len_q),
    .insert_o         (insert_res)
  );

  // Operation select
  always_comb begin
    unique case (func_q) inside
      FUNC_SHL, FUNC_SHR: result_d = {{HalfW{1'b0}}, shift_res};
      FUNC_PRMT:          result_d = {{HalfW{1'b0}}, perm_res};
      FUNC_BFI:           result_d = insert_res;
      default:            result_d = insert_res;
    endcase
  end

  // Result register: strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_word_o  = result_q;

`ifndef SYNTHESIS
  // A result strobe only follows an item that the input register accepted
  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, 2))
    else $error("result strobe without an accepted item");

  // Every accepted item yields a strobe once it has passed the result register
  a_start_gives_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 result_valid_o)
    else $error("accepted item produced no result");

  // 32-bit operations leave the upper half clear
  a_narrow_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ($past(func_i, 2) != FUNC_BFI || !$past(wide_word_i, 2)))
    |-> (result_word_o[WordW-1:HalfW] == '0))
    else $error("upper half set on a 32-bit result");

  // 64-bit insert with zero length passes the base word through
  a_insert_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(func_i, 2) == FUNC_BFI && $past(wide_word_i, 2)
     && $past(field_length_i, 2) == '0)
    |-> (result_word_o == $past(operand_b_i, 2)))
    else $error("zero-length insert altered the base word");
`endif

endmodule

FILE: tb/tb_funnel_shift_byte_permute_bitfield_unit_core.sv
// Self-checking testbench for funnel_shift_byte_permute_bitfield_unit_core: directed
// shift, permute and insert items, then a random mix, each result checked in order.
// Depends on fsbp_pkg and the unit's RTL.
module tb_funnel_shift_byte_permute_bitfield_unit_core;
  import fsbp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned RandomItems = 1900;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  func_e               func_i;
  logic                wide_word_i;
  logic [WordW-1:0]    operand_a_i;
  logic [WordW-1:0]    operand_b_i;
  logic [CountW-1:0]   count_or_selector_i;
  logic [FieldW-1:0]   field_position_i;
  logic [FieldW-1:0]   field_length_i;
  logic                result_valid_o;
  logic [WordW-1:0]    result_word_o;

  logic [WordW-1:0]    expected_words[$];
  int unsigned         mismatch_count;
  int unsigned         cycle_count;
  int unsigned         burst_left;

  funnel_shift_byte_permute_bitfield_unit_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .func_i              (func_i),
    .wide_word_i         (wide_word_i),
    .operand_a_i         (operand_a_i),
    .operand_b_i         (operand_b_i),
    .count_or_selector_i (count_or_selector_i),
    .field_position_i    (field_position_i),
    .field_length_i      (field_length_i),
    .result_valid_o      (result_valid_o),
    .result_word_o       (result_word_o)
  );

  // Clock, period 12
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Expected result of one bit-manipulation item
  function automatic logic [WordW-1:0] predict_bitop(
    input func_e             op,
    input logic              wide,
    input logic [WordW-1:0]  a,
    input logic [WordW-1:0]  b,
    input logic [CountW-1:0] cs,
    input logic [FieldW-1:0] pos,
    input logic [FieldW-1:0] len
  );
    logic [63:0] pair;
    logic [63:0] shifted;
    logic [63:0] res;
    logic [63:0] word_mask;
    logic [63:0] field;
    logic [63:0] ins_mask;
    logic [3:0]  nib;
    logic [7:0]  byt;
    int unsigned word_w;
    int unsigned fld_w;
    pair = {b[31:0], a[31:0]};
    res  = '0;
    case (op)
      FUNC_SHL: begin
        shifted = pair << cs[4:0];
        res = {32'h0, shifted[63:32]};
      end
      FUNC_SHR: begin
        shifted = pair >> cs[4:0];
        res = {32'h0, shifted[31:0]};
      end
      FUNC_PRMT: begin
        for (int lane = 0; lane < 4; lane++) begin
          nib = cs[lane*4 +: 4];
          byt = pair[nib[2:0]*8 +: 8];
          if (nib[3]) byt = {8{byt[7]}};
          res[lane*8 +: 8] = byt;
        end
      end
      default: begin
        word_w    = wide ? 64 : 32;
        word_mask = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        if (len == 0 || pos >= word_w) begin
          res = b & word_mask;
        end else begin
          // clamp the field at the top of the word
          fld_w    = (len < word_w - pos) ? len : word_w - pos;
          field    = (fld_w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << fld_w) - 64'd1);
          ins_mask = (field << pos) & word_mask;
          res = ((b & word_mask & ~ins_mask) | (((a & word_mask) << pos) & ins_mask))
                & word_mask;
        end
      end
    endcase
    return res;
  endfunction

  // Drive one item until accepted, then idle for a random gap unless a burst is running
  task automatic send_op(
    input func_e             op,
    input logic              wide,
    input logic [WordW-1:0]  a,
    input logic [WordW-1:0]  b,
    input logic [CountW-1:0] cs,
    input logic [FieldW-1:0] pos,
    input logic [FieldW-1:0] len
  );
    int unsigned gap;
    @(negedge clk_i);
    start_i             = 1'b1;
    func_i              = op;
    wide_word_i         = wide;
    operand_a_i         = a;
    operand_b_i         = b;
    count_or_selector_i = cs;
    field_position_i    = pos;
    field_length_i      = len;
    do @(posedge clk_i); while (busy_o);
    expected_words.push_back(predict_bitop(op, wide, a, b, cs, pos, len));
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Funnel shifts: zero count, top count, ignored count bits, wide operands
  task automatic test_funnel_shifts();
    send_op(FUNC_SHL, 1'b0, 64'h1111_2222_8765_4321, 64'hAAAA_BBBB_DEAD_BEEF, 32'h0, 8'h0,
            8'h0);
    send_op(FUNC_SHL, 1'b1, 64'hFFFF_FFFF_F000_0001, 64'hFFFF_FFFF_0000_0003, 32'd31,
            8'hFF, 8'hFF);
    send_op(FUNC_SHL, 1'b0, '1, '0, 32'hFFFF_FFE4, 8'h0, 8'h0);
    send_op(FUNC_SHR, 1'b0, 64'hCAFE_0000_1234_5678, 64'h0BAD_0000_9ABC_DEF0, 32'h0,
            8'h0, 8'h0);
    send_op(FUNC_SHR, 1'b1, '0, '1, 32'd31, 8'h80, 8'h01);
    send_op(FUNC_SHR, 1'b0, 64'h8000_0000_8000_0001, 64'h7FFF_FFFF_7FFF_FFFF,
            32'hFFFF_FFFF, 8'h0, 8'h0);
  endtask

  // Byte permute: identity, high word, sign replication, ignored selector bits
  task automatic test_byte_permute();
    send_op(FUNC_PRMT, 1'b0, 64'hFFFF_0000_4433_2211, 64'h0000_FFFF_8877_6655, 32'h3210,
            8'h0, 8'h0);
    send_op(FUNC_PRMT, 1'b1, 64'h4433_2211_4433_2211, 64'h0000_FFFF_8877_6655, 32'h7654,
            8'h0, 8'h0);
    send_op(FUNC_PRMT, 1'b0, 64'h0000_0000_807F_01FF, 64'h0000_0000_7F80_FF00, 32'h8888,
            8'h0, 8'h0);
    send_op(FUNC_PRMT, 1'b0, 64'h0000_0000_807F_01FF, 64'h0000_0000_7F80_FF00,
            32'hFFFF_FCEA, 8'h0, 8'h0);
  endtask

  // Bit-field insert: zero length, outside positions, clamping, full word
  task automatic test_field_insert();
    send_op(FUNC_BFI, 1'b0, '1, 64'hFFFF_0000_1234_5678, 32'h0, 8'd4, 8'd0);
    send_op(FUNC_BFI, 1'b0, '1, 64'hFFFF_0000_0000_0000, 32'h0, 8'd31, 8'd255);
    send_op(FUNC_BFI, 1'b0, '1, 64'hFFFF_0000_5555_AAAA, 32'h0, 8'd32, 8'd8);
    send_op(FUNC_BFI, 1'b0, '1, 64'h1234_5678_9ABC_DEF0, 32'h0, 8'd255, 8'd255);
    send_op(FUNC_BFI, 1'b0, 64'h0000_0000_0000_00AB, '0, 32'h0, 8'd0, 8'd32);
    send_op(FUNC_BFI, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, '0, 32'h0, 8'd0, 8'd64);
    send_op(FUNC_BFI, 1'b1, 64'h0000_0000_0000_0001, '0, 32'h0, 8'd63, 8'd1);
    send_op(FUNC_BFI, 1'b1, '1, 64'h0123_4567_89AB_CDEF, 32'h0, 8'd64, 8'd10);
    send_op(FUNC_BFI, 1'b1, '0, '1, 32'h0, 8'd0, 8'd255);
    send_op(FUNC_BFI, 1'b1, 64'h0000_0000_3FFF_FFFF, 64'h5555_5555_5555_5555, 32'h0,
            8'd40, 8'd30);
    send_op(FUNC_BFI, 1'b1, '1, 64'h0123_4567_89AB_CDEF, 32'h0, 8'd17, 8'd0);
  endtask

  // Random mix of all operations, insert items mostly in-range
  task automatic test_random_mix();
    func_e             op;
    logic              wide;
    logic [FieldW-1:0] pos;
    logic [FieldW-1:0] len;
    int unsigned       word_w;
    for (int i = 0; i < RandomItems; i++) begin
      if (burst_left == 0 && $urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
      op     = func_e'($urandom_range(0, 3));
      wide   = 1'($urandom_range(0, 1));
      word_w = wide ? 64 : 32;
      case ($urandom_range(0, 3))
        3:       pos = FieldW'($urandom_range(0, 255));
        default: pos = FieldW'($urandom_range(0, word_w - 1));
      endcase
      case ($urandom_range(0, 7))
        0:       len = 8'd0;
        1, 2:    len = FieldW'($urandom_range(0, 255));
        default: len = FieldW'($urandom_range(1, word_w));
      endcase
      send_op(op, wide, rand_word(), rand_word(), $urandom(), pos, len);
    end
  endtask

  // Result checker: each strobe against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        $error("result_word: no result expected, actual %h", result_word_o);
        mismatch_count++;
      end else begin
        if (result_word_o !== expected_words[0]) begin
          $error("result_word mismatch: expected %h, actual %h", expected_words[0],
                 result_word_o);
          mismatch_count++;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    start_i             = 1'b0;
    func_i              = FUNC_SHL;
    wide_word_i         = 1'b0;
    operand_a_i         = '0;
    operand_b_i         = '0;
    count_or_selector_i = '0;
    field_position_i    = '0;
    field_length_i      = '0;
    mismatch_count      = 0;
    cycle_count         = 0;
    burst_left          = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_funnel_shifts();
    test_byte_permute();
    test_field_insert();
    test_random_mix();

    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fsbp_pkg.sv
hw/rtl/fsbp_shift_perm.sv
hw/rtl/fsbp_insert.sv
hw/rtl/funnel_shift_byte_permute_bitfield_unit_core.sv
tb/tb_funnel_shift_byte_permute_bitfield_unit_core.sv
